@@ hdl/bra_pkg.sv @@
package bra_pkg;

  localparam int BlockBytes = 512;
  localparam int MaxNameLen = 255;
  localparam int SumW       = 17;
  localparam int HdrBytes   = 2;
  localparam int MinSplit   = HdrBytes + 1;
  localparam logic [15:0] FreeFlag = 16'h8000;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_CHECK = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_H0,
    S_H1,
    S_H2,
    S_W0,
    S_W1,
    S_BW,
    S_BR0,
    S_BR1,
    S_A_TOP,
    S_A_HDR,
    S_A_TAIL,
    S_A_SPLIT,
    S_LD,
    S_M_TOP,
    S_M_HDR,
    S_M_IN,
    S_M_NH,
    S_M_WET,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [8:0] request_length;
    logic [8:0] offset;
    logic [7:0] write_data;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] record_offset;
    logic [8:0] capacity;
    logic [7:0] read_data;
  } out_t;

endpackage

@@ hdl/block_record_allocator.sv @@
// block record allocator
// keeps variable-length records with 2-byte little-endian headers in one
// byte store and serves alloc, free, check, byte write and byte read.
// input channel: in_valid_i / in_stall_o with one in_t item per transfer.
// output channel: out_valid_o / out_stall_i with one out_t result per item.
// every item gives exactly one result, in order.
// after reset the store is cleared one byte per cycle, all BLOCK_BYTES bytes,
// and in_stall_o stays high until that is done.
// one item is worked at a time, in_stall_o is low only in the idle state.
// alloc walks the header chain, each header being two reads of the single
// read port, then writes the new header and, where it fits, a tail or split header.
// free walks the chain twice, once to check it and once to merge.
// a finished result sits in the output register; while out_stall_i holds it
// the next item is still accepted and worked, and the block waits only
// before it would overwrite that result.
module block_record_allocator
  import bra_pkg::*;
#(
  parameter int BLOCK_BYTES  = BlockBytes,
  parameter int MAX_NAME_LEN = MaxNameLen
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam logic [SumW-1:0] Blk  = SumW'(BLOCK_BYTES);
  localparam logic [SumW-1:0] MaxL = SumW'(MAX_NAME_LEN);
  localparam logic [SumW-1:0] Two  = SumW'(HdrBytes);
  localparam logic [SumW-1:0] Split = SumW'(MinSplit);

  logic [7:0] mem_q [BLOCK_BYTES];
  logic [7:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wdat;

  state_e state_q, state_d, ret_q, ret_d;
  logic [AW-1:0] clr_q, clr_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic [2:0] op_q, op_d;
  logic [8:0] len_q, len_d, off_q, off_d;
  logic [7:0] wd_q, wd_d;
  logic [SumW-1:0] pos_q, pos_d, nxt_q, nxt_d, fa_q, fa_d;
  logic [7:0] lo_q, lo_d;
  logic [15:0] hdr_q, hdr_d, fh_q, fh_d, wv_q, wv_d;
  logic [14:0] cap_q, cap_d;
  logic dry_q, dry_d, ovr_q, ovr_d;
  logic [1:0] st_q, st_d;
  logic [8:0] rec_q, rec_d, rcap_q, rcap_d;
  logic [7:0] rdb_q, rdb_d;

  logic [SumW-1:0] len_x, off_x, oa, hcap_x, pos_end, nxt_end, alloc_end, fa1;
  logic [14:0] hcap, merged;
  logic hfree, hzero, recok;

  function automatic logic [7:0] ovr_byte(input logic [SumW-1:0] a, input logic [7:0] d,
                                          input logic en, input logic [SumW-1:0] o,
                                          input logic [15:0] v);
    logic [7:0] r;
    r = d;
    if (en && a == o) r = v[7:0];
    if (en && a == o + Two - SumW'(1)) r = v[15:8];
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wdat;
    rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q  <= ret_d;
    out_q  <= out_d;
    op_q   <= op_d;
    len_q  <= len_d;
    off_q  <= off_d;
    wd_q   <= wd_d;
    pos_q  <= pos_d;
    nxt_q  <= nxt_d;
    fa_q   <= fa_d;
    lo_q   <= lo_d;
    hdr_q  <= hdr_d;
    fh_q   <= fh_d;
    wv_q   <= wv_d;
    cap_q  <= cap_d;
    dry_q  <= dry_d;
    ovr_q  <= ovr_d;
    st_q   <= st_d;
    rec_q  <= rec_d;
    rcap_q <= rcap_d;
    rdb_q  <= rdb_d;
  end

  assign len_x     = SumW'(len_q);
  assign off_x     = SumW'(off_q);
  assign oa        = off_x - Two;
  assign hcap      = hdr_q[14:0];
  assign hfree     = hdr_q[15];
  assign hzero     = (hdr_q == 16'h0000);
  assign hcap_x    = SumW'(hcap);
  assign pos_end   = pos_q + Two + hcap_x;
  assign nxt_end   = nxt_q + Two + hcap_x;
  assign alloc_end = pos_q + Two + len_x;
  assign fa1       = fa_q + SumW'(1);
  assign merged    = cap_q + 15'(HdrBytes) + hcap;
  assign recok     = !hzero && (hcap != '0) && (off_x + hcap_x <= Blk);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    op_d        = op_q;
    len_d       = len_q;
    off_d       = off_q;
    wd_d        = wd_q;
    pos_d       = pos_q;
    nxt_d       = nxt_q;
    fa_d        = fa_q;
    lo_d        = lo_q;
    hdr_d       = hdr_q;
    fh_d        = fh_q;
    wv_d        = wv_q;
    cap_d       = cap_q;
    dry_d       = dry_q;
    ovr_d       = ovr_q;
    st_d        = st_q;
    rec_d       = rec_q;
    rcap_d      = rcap_q;
    rdb_d       = rdb_q;
    mem_we      = 1'b0;
    mem_wa      = fa_q[AW-1:0];
    mem_wdat    = wv_q[7:0];
    mem_ra      = fa_q[AW-1:0];
    in_stall_o  = 1'b1;

    case (state_q)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_wa   = clr_q;
        mem_wdat = 8'h00;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(BLOCK_BYTES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d   = in_data_i.operation;
          len_d  = in_data_i.request_length;
          off_d  = in_data_i.offset;
          wd_d   = in_data_i.write_data;
          st_d   = ST_INVALID;
          rec_d  = '0;
          rcap_d = '0;
          rdb_d  = '0;
          ovr_d  = 1'b0;
          state_d = S_FIN;
          case (in_data_i.operation)
            OP_ALLOC: begin
              if (in_data_i.request_length != '0 &&
                  SumW'(in_data_i.request_length) <= MaxL) begin
                pos_d   = '0;
                state_d = S_A_TOP;
              end
            end
            OP_FREE, OP_CHECK: begin
              if (!(in_data_i.operation == OP_CHECK &&
                    (in_data_i.request_length == '0 ||
                     SumW'(in_data_i.request_length) > MaxL)) &&
                  SumW'(in_data_i.offset) >= Two && SumW'(in_data_i.offset) <= Blk) begin
                fa_d    = SumW'(in_data_i.offset) - Two;
                ret_d   = S_LD;
                state_d = S_H0;
              end
            end
            OP_WRITE: if (SumW'(in_data_i.offset) < Blk) state_d = S_BW;
            OP_READ: begin
              if (SumW'(in_data_i.offset) < Blk) begin
                fa_d    = SumW'(in_data_i.offset);
                state_d = S_BR0;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_H0: begin
        state_d = S_H1;
      end
      S_H1: begin
        mem_ra  = fa1[AW-1:0];
        lo_d    = ovr_byte(fa_q, rdata_q, ovr_q, oa, fh_q);
        state_d = S_H2;
      end
      S_H2: begin
        hdr_d   = {ovr_byte(fa1, rdata_q, ovr_q, oa, fh_q), lo_q};
        state_d = ret_q;
      end
      S_W0: begin
        mem_we  = 1'b1;
        state_d = S_W1;
      end
      S_W1: begin
        mem_we   = 1'b1;
        mem_wa   = fa1[AW-1:0];
        mem_wdat = wv_q[15:8];
        state_d  = ret_q;
      end
      S_BW: begin
        mem_we   = 1'b1;
        mem_wa   = off_q[AW-1:0];
        mem_wdat = wd_q;
        st_d     = ST_OK;
        state_d  = S_FIN;
      end
      S_BR0: begin
        state_d = S_BR1;
      end
      S_BR1: begin
        rdb_d   = rdata_q;
        st_d    = ST_OK;
        state_d = S_FIN;
      end
      S_A_TOP: begin
        if (pos_q + Two > Blk) begin
          st_d    = ST_NOSPACE;
          state_d = S_FIN;
        end else begin
          fa_d    = pos_q;
          ret_d   = S_A_HDR;
          state_d = S_H0;
        end
      end
      S_A_HDR: begin
        if (hzero) begin
          if (alloc_end > Blk) begin
            st_d    = ST_NOSPACE;
            state_d = S_FIN;
          end else begin
            nxt_d   = alloc_end;
            rec_d   = 9'(pos_q + Two);
            st_d    = ST_OK;
            fa_d    = pos_q;
            wv_d    = 16'(len_q);
            ret_d   = S_A_TAIL;
            state_d = S_W0;
          end
        end else if (hcap == '0 || pos_end > Blk) begin
          st_d    = ST_CORRUPT;
          state_d = S_FIN;
        end else if (hfree && hcap_x >= len_x) begin
          rec_d   = 9'(pos_q + Two);
          st_d    = ST_OK;
          fa_d    = pos_q;
          if (hcap_x - len_x >= Split) begin
            nxt_d   = alloc_end;
            cap_d   = hcap - 15'(len_q) - 15'(HdrBytes);
            wv_d    = 16'(len_q);
            ret_d   = S_A_SPLIT;
          end else begin
            wv_d    = {1'b0, hcap};
            ret_d   = S_FIN;
          end
          state_d = S_W0;
        end else begin
          pos_d   = pos_end;
          state_d = S_A_TOP;
        end
      end
      S_A_TAIL: begin
        if (nxt_q + Two <= Blk) begin
          fa_d    = nxt_q;
          wv_d    = 16'h0000;
          ret_d   = S_FIN;
          state_d = S_W0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_A_SPLIT: begin
        fa_d    = nxt_q;
        wv_d    = {1'b1, cap_q};
        ret_d   = S_FIN;
        state_d = S_W0;
      end
      S_LD: begin
        state_d = S_FIN;
        if (recok && !hfree) begin
          if (op_q == OP_FREE) begin
            fh_d    = hdr_q | FreeFlag;
            ovr_d   = 1'b1;
            dry_d   = 1'b1;
            pos_d   = '0;
            state_d = S_M_TOP;
          end else if (len_x <= hcap_x) begin
            st_d   = ST_OK;
            rcap_d = 9'(hcap);
          end
        end
      end
      S_M_TOP: begin
        if (pos_q + Two > Blk) begin
          if (dry_q) begin
            fa_d    = oa;
            wv_d    = fh_q;
            ret_d   = S_M_WET;
            state_d = S_W0;
          end else begin
            st_d    = ST_OK;
            state_d = S_FIN;
          end
        end else begin
          fa_d    = pos_q;
          ret_d   = S_M_HDR;
          state_d = S_H0;
        end
      end
      S_M_WET: begin
        ovr_d   = 1'b0;
        dry_d   = 1'b0;
        pos_d   = '0;
        state_d = S_M_TOP;
      end
      S_M_HDR: begin
        if (hzero) begin
          if (dry_q) begin
            fa_d    = oa;
            wv_d    = fh_q;
            ret_d   = S_M_WET;
            state_d = S_W0;
          end else begin
            st_d    = ST_OK;
            state_d = S_FIN;
          end
        end else if (hcap == '0 || pos_end > Blk) begin
          st_d    = ST_CORRUPT;
          state_d = S_FIN;
        end else begin
          nxt_d = pos_end;
          cap_d = hcap;
          if (hfree) begin
            state_d = S_M_IN;
          end else begin
            pos_d   = pos_end;
            state_d = S_M_TOP;
          end
        end
      end
      S_M_IN: begin
        if (nxt_q + Two > Blk) begin
          pos_d   = nxt_q;
          state_d = S_M_TOP;
        end else begin
          fa_d    = nxt_q;
          ret_d   = S_M_NH;
          state_d = S_H0;
        end
      end
      S_M_NH: begin
        if (hzero) begin
          if (dry_q) begin
            fa_d    = oa;
            wv_d    = fh_q;
            ret_d   = S_M_WET;
            state_d = S_W0;
          end else begin
            st_d    = ST_OK;
            fa_d    = pos_q;
            wv_d    = 16'h0000;
            ret_d   = S_FIN;
            state_d = S_W0;
          end
        end else if (hcap == '0 || nxt_end > Blk) begin
          st_d    = ST_CORRUPT;
          state_d = S_FIN;
        end else if (!hfree) begin
          pos_d   = nxt_q;
          state_d = S_M_TOP;
        end else begin
          cap_d = merged;
          nxt_d = nxt_end;
          if (dry_q) begin
            state_d = S_M_IN;
          end else begin
            fa_d    = pos_q;
            wv_d    = {1'b1, merged};
            ret_d   = S_M_IN;
            state_d = S_W0;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status        = st_q;
          out_d.record_offset = rec_q;
          out_d.capacity      = rcap_q;
          out_d.read_data     = rdb_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sv/bra_checker.sv @@
`timescale 1ns / 1ps

module bra_checker
  import bra_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   ok_count_o,
  output int   result_count_o
);

  logic [7:0] store_model [BlockBytes] = '{default: '0};
  logic [7:0] scratch [BlockBytes];
  out_t       result_queue [$];
  int         fails = 0;
  int         oks = 0;
  int         results = 0;

  function automatic logic [15:0] hdr_rd(int a, logic scr);
    if (scr) return {scratch[a + 1], scratch[a]};
    return {store_model[a + 1], store_model[a]};
  endfunction

  function automatic void hdr_wr(int a, logic [15:0] v, logic scr);
    if (scr) begin
      scratch[a] = v[7:0];
      scratch[a + 1] = v[15:8];
    end else begin
      store_model[a] = v[7:0];
      store_model[a + 1] = v[15:8];
    end
  endfunction

  function automatic status_e place(int need, output int doff);
    int pos;
    int cap;
    int left;
    logic [15:0] h;
    pos = 0;
    doff = 0;
    while (pos + HdrBytes <= BlockBytes) begin
      h = hdr_rd(pos, 1'b0);
      if (h == 0) begin
        if (pos + HdrBytes + need > BlockBytes) return ST_NOSPACE;
        hdr_wr(pos, 16'(need), 1'b0);
        if (pos + 2 * HdrBytes + need <= BlockBytes)
          hdr_wr(pos + HdrBytes + need, 16'h0000, 1'b0);
        doff = pos + HdrBytes;
        return ST_OK;
      end
      cap = int'(h[14:0]);
      if (cap == 0 || pos + HdrBytes + cap > BlockBytes) return ST_CORRUPT;
      if (h[15] && cap >= need) begin
        left = cap - need;
        if (left >= MinSplit) begin
          hdr_wr(pos, 16'(need), 1'b0);
          hdr_wr(pos + HdrBytes + need, 16'(left - HdrBytes) | FreeFlag, 1'b0);
        end else begin
          hdr_wr(pos, 16'(cap), 1'b0);
        end
        doff = pos + HdrBytes;
        return ST_OK;
      end
      pos += HdrBytes + cap;
    end
    return ST_NOSPACE;
  endfunction

  function automatic status_e merge_runs();
    int pos;
    int cap;
    int nxt;
    int ncap;
    logic [15:0] h;
    logic [15:0] nh;
    pos = 0;
    while (pos + HdrBytes <= BlockBytes) begin
      h = hdr_rd(pos, 1'b1);
      if (h == 0) return ST_OK;
      cap = int'(h[14:0]);
      if (cap == 0 || pos + HdrBytes + cap > BlockBytes) return ST_CORRUPT;
      nxt = pos + HdrBytes + cap;
      if (h[15]) begin
        forever begin
          if (nxt + HdrBytes > BlockBytes) break;
          nh = hdr_rd(nxt, 1'b1);
          if (nh == 0) begin
            hdr_wr(pos, 16'h0000, 1'b1);
            return ST_OK;
          end
          ncap = int'(nh[14:0]);
          if (ncap == 0 || nxt + HdrBytes + ncap > BlockBytes) return ST_CORRUPT;
          if (!nh[15]) break;
          cap += HdrBytes + ncap;
          nxt += HdrBytes + ncap;
          hdr_wr(pos, 16'(cap) | FreeFlag, 1'b1);
        end
      end
      pos = nxt;
    end
    return ST_OK;
  endfunction

  function automatic logic load_rec(int off, output int cap, output logic fr);
    logic [15:0] h;
    cap = 0;
    fr = 1'b0;
    if (off < HdrBytes || off > BlockBytes) return 1'b0;
    h = hdr_rd(off - HdrBytes, 1'b0);
    if (h == 0) return 1'b0;
    cap = int'(h[14:0]);
    fr = h[15];
    if (cap == 0 || off + cap > BlockBytes) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_t predict_result(in_t it);
    out_t r;
    int len;
    int off;
    int cap;
    int d;
    logic fr;
    r = '0;
    r.status = ST_INVALID;
    len = int'(it.request_length);
    off = int'(it.offset);
    case (it.operation)
      OP_ALLOC: begin
        if (len != 0 && len <= MaxNameLen) begin
          r.status = place(len, d);
          if (r.status == ST_OK) r.record_offset = 9'(d);
        end
      end
      OP_FREE: begin
        if (load_rec(off, cap, fr) && !fr) begin
          for (int i = 0; i < BlockBytes; i++) scratch[i] = store_model[i];
          hdr_wr(off - HdrBytes, 16'(cap) | FreeFlag, 1'b1);
          r.status = merge_runs();
          if (r.status == ST_OK)
            for (int i = 0; i < BlockBytes; i++) store_model[i] = scratch[i];
        end
      end
      OP_CHECK: begin
        if (len != 0 && len <= MaxNameLen && load_rec(off, cap, fr) && !fr && len <= cap) begin
          r.status = ST_OK;
          r.capacity = 9'(cap);
        end
      end
      OP_WRITE: begin
        if (off < BlockBytes) begin
          store_model[off] = it.write_data;
          r.status = ST_OK;
        end
      end
      OP_READ: begin
        if (off < BlockBytes) begin
          r.read_data = store_model[off];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o      = result_queue.size();
  assign fail_count_o   = fails;
  assign ok_count_o     = oks;
  assign result_count_o = results;

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) result_queue.push_back(predict_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        results <= results + 1;
        if (result_queue.size() == 0) begin
          if (fails < 10) $display("unexpected result %p", out_data_i);
          fails <= fails + 1;
        end else begin
          exp_r = result_queue.pop_front();
          if (exp_r.status == ST_OK) oks <= oks + 1;
          if (exp_r !== out_data_i) begin
            if (fails < 10)
              $display("mismatch: expected %p actual %p", exp_r, out_data_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_block_record_allocator.sv @@
`timescale 1ns / 1ps

module tb_block_record_allocator;
  import bra_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  int   fail_count;
  int   pending;
  int   ok_count;
  int   result_count;
  int   live_offsets [$];

  block_record_allocator uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  bra_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_data_i(in_data_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .ok_count_o(ok_count), .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  task automatic send_item(logic [2:0] op, int len, int off, int wd);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= {op, len[8:0], off[8:0], wd[7:0]};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic random_item();
    int k;
    int off;
    k = $urandom_range(0, 99);
    if (live_offsets.size() > 0) off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
    else off = $urandom_range(0, 511);
    if (k < 30) begin
      send_item(OP_ALLOC, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                : $urandom_range(1, 40), 0, $urandom_range(0, 255));
    end else if (k < 50) begin
      send_item(OP_FREE, $urandom_range(0, 511),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : off, 0);
    end else if (k < 65) begin
      send_item(OP_CHECK, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                : $urandom_range(1, 20), off, $urandom_range(0, 255));
    end else if (k < 72) begin
      send_item(OP_WRITE, $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 255));
    end else if (k < 95) begin
      send_item(OP_READ, $urandom_range(0, 511),
                ($urandom_range(0, 1) == 0) ? off - 2 : $urandom_range(0, 511), 0);
    end else begin
      send_item(3'($urandom_range(5, 7)), $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 255));
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && out_data_o.status == ST_OK &&
        out_data_o.record_offset != 0 && live_offsets.size() < 64)
      live_offsets.push_back(out_data_o.record_offset);
  end

  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(OP_ALLOC, 0, 0, 0);
    send_item(OP_ALLOC, 256, 0, 0);
    send_item(OP_ALLOC, 1, 0, 0);
    send_item(OP_ALLOC, 255, 0, 0);
    send_item(OP_ALLOC, 255, 0, 0);
    send_item(OP_CHECK, 1, 2, 0);
    send_item(OP_CHECK, 2, 2, 0);
    send_item(OP_CHECK, 0, 5, 0);
    send_item(OP_CHECK, 256, 5, 0);
    send_item(OP_CHECK, 255, 5, 0);
    send_item(OP_FREE, 0, 0, 0);
    send_item(OP_FREE, 0, 511, 0);
    send_item(OP_FREE, 0, 2, 0);
    send_item(OP_FREE, 0, 2, 0);
    send_item(OP_CHECK, 1, 2, 0);
    send_item(OP_ALLOC, 1, 0, 0);
    send_item(OP_FREE, 0, 5, 0);
    send_item(OP_WRITE, 0, 511, 255);
    send_item(OP_READ, 0, 511, 0);
    send_item(OP_WRITE, 0, 1, 128);
    send_item(OP_FREE, 0, 5, 0);
    send_item(OP_ALLOC, 4, 0, 0);
    send_item(OP_WRITE, 0, 1, 0);
    send_item(3'd7, 511, 511, 255);
    send_item(3'd5, 0, 0, 0);
    for (int i = 0; i < 400; i++) begin
      random_item();
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d results, %0d with ok status, alloc/free/check/byte access and noise",
             result_count, ok_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int g;
    logic held;
    held = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && result_count >= 175) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        g = gap_len();
        if (g != 0) begin
          out_stall_i <= 1'b1;
          repeat (g) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
